@@ hdl/assert_macros.svh @@
// Assertion macros used by bankers_safety_check_top; clock clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ hdl/bsc_pkg.sv @@
// Package for the safety check block: sizes, request codes and word types.
`default_nettype none
package bsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 16;
  localparam int COUNT_WIDTH   = 16;
  localparam int WORK_WIDTH    = COUNT_WIDTH + 5;

  // process / resource counters must also hold the count itself
  localparam int PC_W = $clog2(MAX_PROCESSES + 1);
  localparam int RC_W = $clog2(MAX_RESOURCES + 1);
  localparam int PI_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RI_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PM_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int PM_AW = (PM_DEPTH > 1) ? $clog2(PM_DEPTH) : 1;

  localparam int CFG_DW = 5;
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_NUM_PROC = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_NUM_RES  = 1'd1;
  localparam logic [CFG_DW-1:0] NUM_RESET    = 5'd16;

  typedef enum logic [1:0] {
    REQ_LOAD_PROC  = 2'd0,
    REQ_LOAD_AVAIL = 2'd1,
    REQ_CHECK      = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  proc_index;
    logic [3:0]  res_index;
    logic [15:0] alloc_value;
    logic [15:0] need_value;
    logic [15:0] avail_value;
  } in_word_t;

  typedef struct packed {
    logic       is_verdict;
    logic [3:0] seq_process;
    logic       is_safe;
    logic       last;
  } out_word_t;

endpackage
`default_nettype wire

@@ hdl/bankers_safety_check_top.sv @@
// Safety check top level: matrix memories, work vector and check sequencer.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_ready   | bsc_pkg::in_word_t
//  out_    | output    | out_valid/out_ready | bsc_pkg::out_word_t
//  cfg_    | input     | cfg_we              | cfg_addr, cfg_data
//
// Loads are accepted in the idle state. A check passes a start state; each pass walks the
// processes, and for each unfinished process the fit test reads and checks each resource
// in turn (single read port of need/alloc memory), the work update reads and writes each
// resource if it fits, then the process is emitted; a last pass test leads to the verdict.
// Reset is synchronous and clears control state only; no clearing pass is needed.
// A full output register stalls the sequencer only when a word is to be emitted.
`default_nettype none
`include "assert_macros.svh"
module bankers_safety_check_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  bsc_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output bsc_pkg::out_word_t   out_data,
  input  wire                  cfg_we,
  input  wire [bsc_pkg::CFG_AW-1:0] cfg_addr,
  input  wire [bsc_pkg::CFG_DW-1:0] cfg_data
);
  import bsc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_PASS, ST_PROC, ST_CMP_RD, ST_CMP_CHK,
    ST_ADD_RD, ST_ADD_WR, ST_EMIT, ST_VERDICT
  } state_t;

  state_t state_r, state_nxt;
  logic [PC_W-1:0] p_r, p_nxt, pass_r, pass_nxt, cnt_r, cnt_nxt;
  logic [RC_W-1:0] r_r, r_nxt;
  logic fits_r, fits_nxt;
  logic [MAX_PROCESSES-1:0] fin_r, fin_nxt;
  logic [MAX_RESOURCES-1:0] wval_r, wval_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  logic [CFG_DW-1:0] num_proc_r, num_proc_nxt, num_res_r, num_res_nxt;

  // memories: need/alloc pairs, available vector, work vector
  logic [2*COUNT_WIDTH-1:0] pm_mem [PM_DEPTH];
  logic [COUNT_WIDTH-1:0]   avail_mem [MAX_RESOURCES];
  logic [WORK_WIDTH-1:0]    work_mem [MAX_RESOURCES];
  logic [2*COUNT_WIDTH-1:0] pm_q;
  logic [COUNT_WIDTH-1:0]   avail_q;
  logic [WORK_WIDTH-1:0]    work_q;

  logic [PC_W-1:0] np;
  logic [RC_W-1:0] nr;
  logic [PI_W-1:0] pi;
  logic [RI_W-1:0] ri;
  logic [PM_AW-1:0] pm_raddr, pm_waddr;
  logic [RI_W-1:0] ld_ri;
  logic in_acc, ld_proc_we, ld_avail_we, rd_en, slot_free, r_last, fit_now;
  logic [COUNT_WIDTH-1:0] need_q, alloc_q;
  logic [WORK_WIDTH-1:0] work_cur, work_sum;
  logic [WORK_WIDTH:0] sum_wide;

  assign np = (int'(num_proc_r) > MAX_PROCESSES) ? PC_W'(MAX_PROCESSES) : PC_W'(num_proc_r);
  assign nr = (int'(num_res_r) > MAX_RESOURCES) ? RC_W'(MAX_RESOURCES) : RC_W'(num_res_r);
  assign pi = p_r[PI_W-1:0];
  assign ri = r_r[RI_W-1:0];

  assign in_ready    = (state_r == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign ld_proc_we  = in_acc && (in_data.req_type == REQ_LOAD_PROC) &&
                       (int'(in_data.proc_index) < MAX_PROCESSES) &&
                       (int'(in_data.res_index) < MAX_RESOURCES);
  assign ld_avail_we = in_acc && (in_data.req_type == REQ_LOAD_AVAIL) &&
                       (int'(in_data.res_index) < MAX_RESOURCES);
  assign pm_waddr = PM_AW'(int'(in_data.proc_index) * MAX_RESOURCES + int'(in_data.res_index));
  assign pm_raddr = PM_AW'(int'(pi) * MAX_RESOURCES + int'(ri));
  assign ld_ri    = RI_W'(in_data.res_index);
  assign rd_en    = (state_r == ST_CMP_RD) || (state_r == ST_ADD_RD);

  // word layout: alloc in the upper half, need in the lower
  assign alloc_q  = pm_q[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign need_q   = pm_q[COUNT_WIDTH-1:0];
  assign work_cur = wval_r[ri] ? work_q : WORK_WIDTH'(avail_q);
  assign sum_wide = {1'b0, work_cur} + (WORK_WIDTH+1)'(alloc_q);
  assign work_sum = sum_wide[WORK_WIDTH] ? {WORK_WIDTH{1'b1}} : sum_wide[WORK_WIDTH-1:0];
  assign fit_now  = fits_r && (WORK_WIDTH'(need_q) <= work_cur);
  assign r_last   = (r_r + RC_W'(1)) == nr;
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ld_proc_we) begin
      pm_mem[pm_waddr] <= {COUNT_WIDTH'(in_data.alloc_value), COUNT_WIDTH'(in_data.need_value)};
    end
    if (rd_en) begin
      pm_q <= pm_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_avail_we) begin
      avail_mem[ld_ri] <= COUNT_WIDTH'(in_data.avail_value);
    end
    if (rd_en) begin
      avail_q <= avail_mem[ri];
    end
  end

  // written in ST_ADD_WR, the state after its read in ST_ADD_RD; the next read of the same entry comes later
  always_ff @(posedge clk) begin
    if (state_r == ST_ADD_WR) begin
      work_mem[ri] <= work_sum;
    end
    if (rd_en) begin
      work_q <= work_mem[ri];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    pass_nxt      = pass_r;
    cnt_nxt       = cnt_r;
    r_nxt         = r_r;
    fits_nxt      = fits_r;
    fin_nxt       = fin_r;
    wval_nxt      = wval_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    num_proc_nxt  = num_proc_r;
    num_res_nxt   = num_res_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_PROC: num_proc_nxt = cfg_data;
        CFG_NUM_RES:  num_res_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_CHECK)) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        fin_nxt   = '0;
        cnt_nxt   = '0;
        wval_nxt  = '0;
        pass_nxt  = '0;
        state_nxt = ST_PASS;
      end
      ST_PASS: begin
        if ((pass_r < np) && (cnt_r < np)) begin
          p_nxt     = '0;
          state_nxt = ST_PROC;
        end else begin
          state_nxt = ST_VERDICT;
        end
      end
      ST_PROC: begin
        if (p_r == np) begin
          pass_nxt  = pass_r + PC_W'(1);
          state_nxt = ST_PASS;
        end else if (fin_r[pi]) begin
          p_nxt = p_r + PC_W'(1);
        end else begin
          r_nxt     = '0;
          fits_nxt  = 1'b1;
          state_nxt = (nr == '0) ? ST_EMIT : ST_CMP_RD;
        end
      end
      ST_CMP_RD: state_nxt = ST_CMP_CHK;
      ST_CMP_CHK: begin
        fits_nxt = fit_now;
        if (!r_last) begin
          r_nxt     = r_r + RC_W'(1);
          state_nxt = ST_CMP_RD;
        end else if (fit_now) begin
          r_nxt     = '0;
          state_nxt = ST_ADD_RD;
        end else begin
          p_nxt     = p_r + PC_W'(1);
          state_nxt = ST_PROC;
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: begin
        wval_nxt[ri] = 1'b1;
        if (r_last) begin
          state_nxt = ST_EMIT;
        end else begin
          r_nxt     = r_r + RC_W'(1);
          state_nxt = ST_ADD_RD;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.is_verdict  = 1'b0;
          out_data_nxt.seq_process = 4'(pi);
          out_data_nxt.is_safe     = 1'b0;
          out_data_nxt.last        = 1'b0;
          fin_nxt[pi]              = 1'b1;
          cnt_nxt                  = cnt_r + PC_W'(1);
          p_nxt                    = p_r + PC_W'(1);
          state_nxt                = ST_PROC;
        end
      end
      ST_VERDICT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.is_verdict  = 1'b1;
          out_data_nxt.seq_process = '0;
          out_data_nxt.is_safe     = (cnt_r == np);
          out_data_nxt.last        = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= '0;
      pass_r      <= '0;
      cnt_r       <= '0;
      r_r         <= '0;
      fits_r      <= 1'b0;
      fin_r       <= '0;
      wval_r      <= '0;
      out_valid_r <= 1'b0;
      num_proc_r  <= NUM_RESET;
      num_res_r   <= NUM_RESET;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      pass_r      <= pass_nxt;
      cnt_r       <= cnt_nxt;
      r_r         <= r_nxt;
      fits_r      <= fits_nxt;
      fin_r       <= fin_nxt;
      wval_r      <= wval_nxt;
      out_valid_r <= out_valid_nxt;
      num_proc_r  <= num_proc_nxt;
      num_res_r   <= num_res_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // finish count tracks the marks
  `ASSERT_CLK(a_cnt_marks, $countones(fin_r) == int'(cnt_r), "finish count off marks")
  // a process is emitted at most once per check
  `ASSERT_NEVER(a_emit_twice, (state_r == ST_EMIT) && slot_free && fin_r[pi],
    "finished process emitted again")
  // work update only follows a passed fit test
  `ASSERT_CLK(a_add_fits, ((state_r == ST_ADD_RD) || (state_r == ST_ADD_WR)) |-> fits_r,
    "work update without fit")

endmodule
`default_nettype wire

@@ sim/tb_bankers_safety_check_top.sv @@
// Testbench for bankers_safety_check_top: safe sequences and verdicts checked against a predictor.
`timescale 1ns / 100ps
module tb_bankers_safety_check_top;
  import bsc_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;

  bankers_safety_check_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the matrices, available vector and count registers
  logic [COUNT_WIDTH-1:0] alloc_m [MAX_PROCESSES][MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] need_m  [MAX_PROCESSES][MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] avail_m [MAX_RESOURCES];
  bit                     entry_written [MAX_PROCESSES][MAX_RESOURCES];
  logic [CFG_DW-1:0]      np_reg = NUM_RESET;
  logic [CFG_DW-1:0]      nr_reg = NUM_RESET;

  out_word_t safe_seq_q[$];
  int        errors        = 0;
  int        checks_run    = 0;
  int        safe_verdicts = 0;
  int        words_checked = 0;
  int        items_sent    = 0;
  bit        quiet         = 1'b0;
  int        value_bits    = 16;

  function automatic int eff_count(input logic [CFG_DW-1:0] v, input int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic logic [15:0] rand_count();
    return 16'($urandom_range(65535) & ((1 << value_bits) - 1));
  endfunction

  // every field but the request code random; builders below overwrite the ones that matter
  function automatic in_word_t noise_word();
    in_word_t w;
    w.req_type    = REQ_NONE;
    w.proc_index  = 4'($urandom_range(15));
    w.res_index   = 4'($urandom_range(15));
    w.alloc_value = 16'($urandom_range(65535));
    w.need_value  = 16'($urandom_range(65535));
    w.avail_value = 16'($urandom_range(65535));
    return w;
  endfunction

  function automatic in_word_t proc_load(input int p, input int r,
                                         input logic [15:0] a, input logic [15:0] n);
    in_word_t w;
    w = noise_word();
    w.req_type    = REQ_LOAD_PROC;
    w.proc_index  = 4'(p);
    w.res_index   = 4'(r);
    w.alloc_value = a;
    w.need_value  = n;
    return w;
  endfunction

  function automatic in_word_t avail_load(input int r, input logic [15:0] v);
    in_word_t w;
    w = noise_word();
    w.req_type    = REQ_LOAD_AVAIL;
    w.res_index   = 4'(r);
    w.avail_value = v;
    return w;
  endfunction

  function automatic in_word_t check_req();
    in_word_t w;
    w = noise_word();
    w.req_type = REQ_CHECK;
    return w;
  endfunction

  task automatic run_safety();
    logic [WORK_WIDTH-1:0] work [MAX_RESOURCES];
    logic [WORK_WIDTH:0]   sum;
    bit                    fin_mark [MAX_PROCESSES];
    int                    np, nr, fin_cnt, pass, p, r;
    bit                    fits;
    out_word_t             w;
    np      = eff_count(np_reg, MAX_PROCESSES);
    nr      = eff_count(nr_reg, MAX_RESOURCES);
    fin_cnt = 0;
    for (r = 0; r < MAX_RESOURCES; r++) work[r] = avail_m[r];
    for (p = 0; p < MAX_PROCESSES; p++) fin_mark[p] = 1'b0;
    for (pass = 0; pass < np && fin_cnt < np; pass++) begin
      for (p = 0; p < np; p++) begin
        if (!fin_mark[p]) begin
          fits = 1'b1;
          for (r = 0; r < nr; r++)
            if (need_m[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            // work saturates rather than wrapping
            for (r = 0; r < nr; r++) begin
              sum     = work[r] + alloc_m[p][r];
              work[r] = sum[WORK_WIDTH] ? '1 : sum[WORK_WIDTH-1:0];
            end
            fin_mark[p] = 1'b1;
            fin_cnt++;
            w = '0;
            w.seq_process = 4'(p);
            safe_seq_q.push_back(w);
          end
        end
      end
    end
    w = '0;
    w.is_verdict = 1'b1;
    w.is_safe    = (fin_cnt == np);
    w.last       = 1'b1;
    safe_seq_q.push_back(w);
    checks_run++;
    if (fin_cnt == np) safe_verdicts++;
  endtask

  task automatic model_request(input in_word_t w);
    case (w.req_type)
      REQ_LOAD_PROC: begin
        alloc_m[w.proc_index][w.res_index]       = w.alloc_value;
        need_m[w.proc_index][w.res_index]        = w.need_value;
        entry_written[w.proc_index][w.res_index] = 1'b1;
      end
      REQ_LOAD_AVAIL: avail_m[w.res_index] = w.avail_value;
      REQ_CHECK: run_safety();
      default: ;
    endcase
    if (w.req_type != REQ_NONE) items_sent++;
  endtask

  task automatic send_word(input in_word_t w);
    if (!quiet) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    model_request(w);
  endtask

  // loads any entry of the active region not yet written, so a check never reads junk
  task automatic fill_region();
    int np, nr, p, r;
    np = eff_count(np_reg, MAX_PROCESSES);
    nr = eff_count(nr_reg, MAX_RESOURCES);
    for (p = 0; p < np; p++)
      for (r = 0; r < nr; r++)
        if (!entry_written[p][r]) send_word(proc_load(p, r, rand_count(), rand_count()));
  endtask

  task automatic issue_check();
    fill_region();
    send_word(check_req());
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    in_valid <= 1'b0;
    while (safe_seq_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_PROC) np_reg = val;
    else nr_reg = val;
  endtask

  task automatic compare_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t exp_w;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (safe_seq_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected nothing, actual %p",
                 $time, out_data);
      end else begin
        exp_w = safe_seq_q.pop_front();
        words_checked++;
        compare_field("is_verdict",  4'(exp_w.is_verdict), 4'(out_data.is_verdict));
        compare_field("seq_process", exp_w.seq_process,    out_data.seq_process);
        compare_field("is_safe",     4'(exp_w.is_safe),    4'(out_data.is_safe));
        compare_field("last",        4'(exp_w.last),       4'(out_data.last));
      end
    end
  end

  always @(posedge clk)
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(99) >= 11);

  // single process/resource, value extremes, ignored request code
  task automatic test_edge_values();
    int r;
    write_reg(CFG_NUM_PROC, 5'd1);
    write_reg(CFG_NUM_RES, 5'd1);
    for (r = 0; r < MAX_RESOURCES; r++)
      send_word(avail_load(r, (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF
                                                   : 16'($urandom_range(65535))));
    send_word(proc_load(0, 0, 16'hFFFF, 16'hFFFF));
    issue_check();
    send_word(avail_load(0, 16'hFFFF));
    issue_check();
    send_word(proc_load(15, 15, 16'h0000, 16'h0000));
    send_word(noise_word());
    send_word(proc_load(0, 0, 16'h0000, 16'h0000));
    send_word(avail_load(0, 16'h0000));
    issue_check();
  endtask

  // zero processes gives the bare verdict; zero resources lets all finish
  task automatic test_zero_counts();
    write_reg(CFG_NUM_PROC, 5'd0);
    issue_check();
    write_reg(CFG_NUM_PROC, 5'd4);
    write_reg(CFG_NUM_RES, 5'd0);
    issue_check();
    write_reg(CFG_NUM_RES, 5'd1);
    value_bits = 2;
    issue_check();
  endtask

  // counts above the maximum clamp, on a full column and then on a full row
  task automatic test_full_size();
    int r;
    write_reg(CFG_NUM_PROC, 5'd31);
    write_reg(CFG_NUM_RES, 5'd1);
    value_bits = 4;
    for (r = 0; r < MAX_RESOURCES; r++) send_word(avail_load(r, rand_count()));
    issue_check();
    write_reg(CFG_NUM_PROC, 5'd1);
    write_reg(CFG_NUM_RES, 5'd20);
    issue_check();
  endtask

  // mostly load-then-check sequences with random content, some noise and repeat checks
  task automatic test_random_traffic();
    int start, nloads, k, np, nr;
    start = items_sent;
    while (items_sent < start + 80) begin
      quiet = (items_sent >= start + 30) && (items_sent < start + 60);
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_NUM_PROC, ($urandom_range(9) == 0) ? 5'($urandom_range(7, 31))
                                                         : 5'($urandom_range(1, 6)));
        write_reg(CFG_NUM_RES, ($urandom_range(9) == 0) ? 5'($urandom_range(1, 31))
                                                        : 5'($urandom_range(1, 6)));
      end
      np = eff_count(np_reg, MAX_PROCESSES);
      nr = eff_count(nr_reg, MAX_RESOURCES);
      value_bits = $urandom_range(1, 16);
      nloads = $urandom_range(0, 8);
      repeat (nloads) begin
        k = $urandom_range(99);
        if (k < 60)
          send_word(proc_load($urandom_range(np - 1), $urandom_range(nr - 1),
                              rand_count(), rand_count()));
        else if (k < 85)
          send_word(avail_load($urandom_range(15), rand_count()));
        else if (k < 93)
          send_word(proc_load($urandom_range(15), $urandom_range(15),
                              rand_count(), rand_count()));
        else
          send_word(noise_word());
      end
      issue_check();
      if ($urandom_range(4) == 0) send_word(check_req());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_values();
    test_zero_counts();
    test_full_size();
    test_random_traffic();
    in_valid <= 1'b0;
    while (safe_seq_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("summary: %0d requests, %0d safety checks (%0d safe), %0d result words compared",
             items_sent, checks_run, safe_verdicts, words_checked);
    $display("summary: counts 0 to 31 written, 16 processes or 16 resources at most, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
